/* rtl/nwa_pkg.sv */
// nwa_pkg: item types, register indexes and fixed widths for the
// normalized window average unit; no dependencies
package nwa_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int SUM_W       = 39;
    localparam int COUNT_W     = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AVG_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_BOUND   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_RANGE   = 2'd3;

    localparam logic [0:0] CMD_ADD   = 1'b0;
    localparam logic [0:0] CMD_CLEAR = 1'b1;

    localparam logic [6:0]  WINDOW_SIZE_RESET = 7'd100;
    localparam logic [16:0] INV_RANGE_RESET   = 17'd65536;

    typedef struct packed {
        logic [0:0]         command;
        logic signed [15:0] sample;
    } item_t;

    typedef struct packed {
        logic signed [31:0]  normalized;
        logic signed [31:0]  average;
        logic [COUNT_W-1:0]  held_count;
    } result_t;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/nwa_ring.sv */
// nwa_ring: history store of normalized values, one write and one
// registered read port; depends on nothing
module nwa_ring #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/nwa_div.sv */
// nwa_div: serial signed divider, one quotient bit per cycle, sum over count
// depends on nwa_pkg
module nwa_div
    import nwa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_ctrl_t               ctrl,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [COUNT_W-1:0]      divisor,
    output div_stat_t               stat,
    output logic signed [31:0]      quotient
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] div_reg;

    logic [COUNT_W:0]   shifted;
    logic               fits;
    logic [COUNT_W:0]   trial;
    logic [SUM_W-1:0]   mag;
    logic [SUM_W-1:0]   signed_quo;

    assign mag     = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= !ctrl.start && busy_reg && (step_reg == STEP_LAST);
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the count width
            rem_reg <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[31:0];
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

/* rtl/normalized_window_average_unit.sv */
// normalized_window_average_unit: normalizes each sample, keeps a ring of the
// newest values and reports their mean; depends on nwa_pkg, nwa_ring, nwa_div
// an add item is normalized and written, then n values are read back and divided, where n
// is the number of values averaged (one ring read per cycle, then 39 divider steps)
// an add item holds the input until its result is loaded, a clear item goes straight
// to the finish state; next item accepted once the sequencer is back at rest, even while
// the last result waits; a result still unread stalls the following one at its end
// reset (rst_n low, asynchronous) empties the history and loads register defaults
module normalized_window_average_unit
    import nwa_pkg::*;
#(
    parameter int RING_DEPTH = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SAT  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIVS = 3'd3;
    localparam logic [2:0] ST_DIVW = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // configuration registers
    logic [6:0]         window_size_reg;
    logic [6:0]         avg_count_reg;
    logic signed [15:0] low_bound_reg;
    logic [16:0]        inv_range_reg;

    // history bookkeeping
    logic [2:0]               state_reg;
    logic [PTR_W-1:0]         wr_ptr_reg;
    logic [COUNT_W-1:0]       held_reg;
    logic [COUNT_W-1:0]       n_reg;
    logic [COUNT_W-1:0]       issue_cnt_reg;
    logic [COUNT_W-1:0]       acc_cnt_reg;
    logic [PTR_W-1:0]         rd_ptr_reg;
    logic                     rd_valid_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     result_valid_reg;

    // payload
    logic signed [34:0] prod_reg;
    logic signed [31:0] norm_reg;
    logic signed [31:0] avg_reg;
    result_t            result_reg;

    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [31:0] norm_sat;
    logic [6:0]         win_nz;
    logic [6:0]         win;
    logic [COUNT_W:0]   held_inc;
    logic [COUNT_W-1:0] held_next;
    logic [COUNT_W-1:0] n_next;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic               rd_en;
    logic [31:0]        rd_data;
    logic               ring_wr;
    logic               accept;
    logic               load_result;
    div_ctrl_t          div_ctrl;
    div_stat_t          div_stat;
    logic signed [31:0] quotient;

    assign accept     = item_valid && item_ready;
    assign item_ready = state_reg == ST_IDLE;
    assign cfg_ready  = 1'b1;

    // normalizing multiply: 17-bit signed difference by unsigned Q1.16 scale
    assign diff = 17'(item.sample) - 17'(low_bound_reg);
    assign prod = 35'(diff) * $signed({18'd0, inv_range_reg});

    // saturate to the signed 32-bit range when the upper bits disagree
    always_comb
    begin
        if (prod_reg[34:31] == {4{prod_reg[34]}})
        begin
            norm_sat = prod_reg[31:0];
        end
        else if (prod_reg[34])
        begin
            norm_sat = 32'sh8000_0000;
        end
        else
        begin
            norm_sat = 32'sh7FFF_FFFF;
        end
    end

    // effective window: zero acts as one, capped by the ring depth
    assign win_nz = (window_size_reg == '0) ? 7'd1 : window_size_reg;
    assign win    = (32'(win_nz) > RING_DEPTH) ? 7'(RING_DEPTH) : win_nz;

    assign held_inc  = {1'b0, held_reg} + 1'b1;
    assign held_next = (held_inc > {1'b0, win}) ? win : held_inc[COUNT_W-1:0];
    assign n_next    = (avg_count_reg != '0 && avg_count_reg < held_next)
                       ? avg_count_reg : held_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - 1'b1;

    // walk back from the newest entry, one read per cycle
    assign rd_en   = (state_reg == ST_ACC) && (issue_cnt_reg != n_reg);
    assign ring_wr = state_reg == ST_SAT;

    assign div_ctrl.start = state_reg == ST_DIVS;
    assign load_result    = (state_reg == ST_FIN) && (!result_valid_reg || result_ready);

    nwa_ring #(
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (norm_sat),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    nwa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            avg_count_reg   <= '0;
            low_bound_reg   <= '0;
            inv_range_reg   <= INV_RANGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[6:0];
                REG_AVG_COUNT:   avg_count_reg   <= cfg_data[6:0];
                REG_LOW_BOUND:   low_bound_reg   <= cfg_data[15:0];
                REG_INV_RANGE:   inv_range_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // sequencer and history bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wr_ptr_reg       <= '0;
            held_reg         <= '0;
            n_reg            <= '0;
            issue_cnt_reg    <= '0;
            acc_cnt_reg      <= '0;
            rd_ptr_reg       <= '0;
            rd_valid_reg     <= 1'b0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            // a new result may replace the one taken in the same cycle
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.command == CMD_CLEAR)
                        begin
                            // empty the store, results go out as zeros
                            wr_ptr_reg <= '0;
                            held_reg   <= '0;
                            sum_reg    <= '0;
                            state_reg  <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_SAT;
                        end
                    end
                end
                ST_SAT:
                begin
                    // ring write happens this cycle, reads start at this slot
                    wr_ptr_reg    <= wr_ptr_next;
                    held_reg      <= held_next;
                    n_reg         <= n_next;
                    rd_ptr_reg    <= wr_ptr_reg;
                    issue_cnt_reg <= '0;
                    acc_cnt_reg   <= '0;
                    sum_reg       <= '0;
                    state_reg     <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (rd_en)
                    begin
                        rd_ptr_reg    <= rd_ptr_next;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (rd_valid_reg)
                    begin
                        sum_reg     <= sum_reg + SUM_W'($signed(rd_data));
                        acc_cnt_reg <= acc_cnt_reg + 1'b1;
                        if (acc_cnt_reg + 1'b1 == n_reg)
                        begin
                            state_reg <= ST_DIVS;
                        end
                    end
                end
                ST_DIVS:
                begin
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (load_result)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod;
            norm_reg <= '0;
            avg_reg  <= '0;
        end
        if (state_reg == ST_SAT)
        begin
            norm_reg <= norm_sat;
        end
        if (state_reg == ST_DIVW && div_stat.done)
        begin
            avg_reg <= quotient;
        end
        if (load_result)
        begin
            result_reg.normalized <= norm_reg;
            result_reg.average    <= avg_reg;
            result_reg.held_count <= held_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/tb_normalized_window_average_unit.sv */
// tb_normalized_window_average_unit: self-checking bench for the normalized window
// average unit; a directed table first, then random register settings and item streams
// depends on nwa_pkg and normalized_window_average_unit
module tb_normalized_window_average_unit;
    import nwa_pkg::*;

    localparam int HIST_DEPTH   = 128;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int ITEM_TARGET  = 1150;
    localparam int LONG_RUN     = 200;
    localparam int SQUEEZE_LEN  = 600;
    localparam int SETTLE_LEN   = 250;
    localparam int REPORT_LIMIT = 10;

    // signed 32-bit saturation limits of the normalized value
    localparam longint NORM_MAX = 64'sh7FFF_FFFF;
    localparam longint NORM_MIN = -64'sh8000_0000;

    // one row of the directed table: a register write or an item,
    // with the result typed in where it is obvious
    typedef struct packed {
        logic                   is_reg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        item_t                  stim;
        logic                   typed;
        result_t                want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shaping of the traffic: steady and squeeze_request set by the stimulus process, the rest by the result side
    logic steady = 1'b0;
    logic squeeze_request = 1'b0;
    logic squeeze_done = 1'b0;
    int   squeeze_left = 0;

    // filter state as the bench expects it to be
    logic signed [31:0]  norm_hist [HIST_DEPTH];
    logic [HIST_AW-1:0]  hist_wr;
    int                  held;
    logic [6:0]          cur_window;
    logic [6:0]          cur_avg_n;
    logic signed [15:0]  cur_low;
    logic [16:0]         cur_scale;

    // results owed by the block, oldest first
    result_t   awaited [$];
    plan_row_t plan [$];

    int items_sent = 0;
    int clears_sent = 0;
    int reg_writes = 0;
    int results_checked = 0;
    int fault_count = 0;

    normalized_window_average_unit #(
        .RING_DEPTH(HIST_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter behavior for one accepted item; updates the expected state
    function automatic result_t next_filter_output(input item_t it);
        result_t            out;
        longint             offset;
        longint             scaled;
        longint             window_sum;
        int                 win;
        int                 n;
        int                 i;
        logic [HIST_AW-1:0] idx;
        out = '0;
        // clear empties the history and reports all zeros
        if (it.command == CMD_CLEAR)
        begin
            hist_wr = '0;
            held = 0;
            return out;
        end
        offset = longint'($signed(it.sample)) - longint'(cur_low);
        scaled = offset * longint'(cur_scale);
        if (scaled > NORM_MAX)
            out.normalized = NORM_MAX[31:0];
        else if (scaled < NORM_MIN)
            out.normalized = NORM_MIN[31:0];
        else
            out.normalized = scaled[31:0];
        norm_hist[hist_wr] = out.normalized;
        hist_wr = hist_wr + 1'b1;
        // a zero window keeps one value, nothing beyond the ring depth
        win = (cur_window == '0) ? 1 : int'(cur_window);
        if (win > HIST_DEPTH)
            win = HIST_DEPTH;
        // a shrunk window cuts the held count here
        held = (held + 1 > win) ? win : held + 1;
        // zero or an oversized count averages everything held
        n = held;
        if (cur_avg_n != '0 && int'(cur_avg_n) < n)
            n = int'(cur_avg_n);
        window_sum = 0;
        for (i = 0; i < n; i++)
        begin
            idx = HIST_AW'(hist_wr - 1 - i);
            window_sum += longint'(norm_hist[idx]);
        end
        // at least the new value is held, so n is never zero here
        out.average = 32'(window_sum / longint'(n));
        out.held_count = 7'(held);
        return out;
    endfunction

    task automatic plan_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_index = idx;
        r.reg_value = data;
        plan.insert(plan.size(), r);
    endtask

    task automatic plan_item(input logic [0:0] cmd, input logic [15:0] smp);
        plan_row_t r;
        r = '0;
        r.stim.command = cmd;
        r.stim.sample = smp;
        plan.insert(plan.size(), r);
    endtask

    task automatic plan_known(input logic [0:0] cmd, input logic [15:0] smp,
                              input logic [31:0] nv, input logic [31:0] av,
                              input logic [6:0] hc);
        plan_row_t r;
        r = '0;
        r.stim.command = cmd;
        r.stim.sample = smp;
        r.typed = 1'b1;
        r.want.normalized = nv;
        r.want.average = av;
        r.want.held_count = hc;
        plan.insert(plan.size(), r);
    endtask

    // waits until every owed result has been taken
    task automatic wait_drained();
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no drop
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            REG_WINDOW_SIZE: cur_window = data[6:0];
            REG_AVG_COUNT:   cur_avg_n = data[6:0];
            REG_LOW_BOUND:   cur_low = data[15:0];
            REG_INV_RANGE:   cur_scale = data;
            default:         ;
        endcase
    endtask

    // offers one item with random gaps in front unless steady, and records what it owes
    task automatic offer_item(input item_t it, input logic typed, input result_t want);
        result_t predicted;
        while (!steady && $urandom_range(0, 99) < 10)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        if (it.command == CMD_CLEAR)
            clears_sent++;
        predicted = next_filter_output(it);
        awaited.insert(awaited.size(), typed ? want : predicted);
    endtask

    // stops the item stream, waits for quiet, then loads all four registers;
    // unused upper data bits carry junk
    task automatic program_phase(input logic [6:0] ws, input logic [6:0] ac,
                                 input logic [15:0] lb, input logic [16:0] ir);
        item_valid <= 1'b0;
        wait_drained();
        write_reg(REG_WINDOW_SIZE, {10'($urandom), ws});
        write_reg(REG_AVG_COUNT, {10'($urandom), ac});
        write_reg(REG_LOW_BOUND, {1'($urandom), lb});
        write_reg(REG_INV_RANGE, ir);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t random_item(input int clear_pct);
        item_t it;
        it.command = ($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_ADD;
        case ($urandom_range(0, 9))
            0:       it.sample = 16'sh7FFF;
            1:       it.sample = 16'sh8000;
            2:       it.sample = cur_low;       // maps to zero
            default: it.sample = 16'($urandom);
        endcase
        return it;
    endfunction

    // result side: checks every taken item, stalls at random and once for a long
    // stretch so the block backs up into its input
    always @(posedge clk)
    begin : result_side
        result_t want;
        logic    bad;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (awaited.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected result: normalized %0d average %0d held %0d",
                                 result.normalized, result.average, result.held_count);
                end
                else
                begin
                    want = awaited.pop_front();
                    results_checked++;
                    bad = 1'b0;
                    if (result.normalized !== want.normalized)
                        bad = 1'b1;
                    if (result.average !== want.average)
                        bad = 1'b1;
                    if (result.held_count !== want.held_count)
                        bad = 1'b1;
                    if (bad)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"result %0d mismatch: normalized exp %0d got %0d, ",
                                      "average exp %0d got %0d, held exp %0d got %0d"},
                                     results_checked, want.normalized, result.normalized,
                                     want.average, result.average,
                                     want.held_count, result.held_count);
                    end
                end
            end
            // next ready value
            if (squeeze_left != 0)
            begin
                squeeze_left <= squeeze_left - 1;
                result_ready <= 1'b0;
            end
            else if (squeeze_request && !squeeze_done)
            begin
                squeeze_done <= 1'b1;
                squeeze_left <= SQUEEZE_LEN;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial
    begin
        plan_row_t  row;
        logic       cfg_open;
        item_t      it;
        int         phase;
        int         k;
        int         run_len;
        logic [6:0] ws;
        logic [6:0] ac;
        logic [15:0] lb;
        logic [16:0] ir;

        // expected state after reset
        cur_window = WINDOW_SIZE_RESET;
        cur_avg_n = '0;
        cur_low = '0;
        cur_scale = INV_RANGE_RESET;
        hist_wr = '0;
        held = 0;

        // defaults: unity scale, zero offset, window of 100
        plan_known(CMD_ADD, 16'h7FFF, 32'h7FFF0000, 32'h7FFF0000, 7'd1);
        plan_known(CMD_ADD, 16'h8000, 32'h80000000, 32'hFFFF8000, 7'd2);
        plan_known(CMD_CLEAR, 16'h1234, 32'h0, 32'h0, 7'd0);
        // clear of an empty store
        plan_known(CMD_CLEAR, 16'hFFFF, 32'h0, 32'h0, 7'd0);
        plan_known(CMD_ADD, 16'h0000, 32'h0, 32'h0, 7'd1);
        plan_known(CMD_ADD, 16'h0001, 32'h00010000, 32'h00008000, 7'd2);
        plan_known(CMD_ADD, 16'hFFFF, 32'hFFFF0000, 32'h0, 7'd3);
        // largest offset span and largest scale: both saturation limits
        plan_reg(REG_LOW_BOUND, 17'h08000);
        plan_reg(REG_INV_RANGE, 17'h1FFFF);
        plan_item(CMD_ADD, 16'h7FFF);
        plan_reg(REG_LOW_BOUND, 17'h07FFF);
        plan_item(CMD_ADD, 16'h8000);
        plan_item(CMD_ADD, 16'h7FFF);
        // zero scale
        plan_reg(REG_INV_RANGE, 17'h00000);
        plan_item(CMD_ADD, 16'h04D2);
        // zero window behaves as a window of one
        plan_reg(REG_WINDOW_SIZE, 17'd0);
        plan_reg(REG_INV_RANGE, 17'h10000);
        plan_reg(REG_LOW_BOUND, 17'h00000);
        plan_known(CMD_ADD, 16'h0005, 32'h00050000, 32'h00050000, 7'd1);
        plan_known(CMD_ADD, 16'hFFFB, 32'hFFFB0000, 32'hFFFB0000, 7'd1);
        // widest window and widest average count
        plan_reg(REG_WINDOW_SIZE, 17'd127);
        plan_reg(REG_AVG_COUNT, 17'd127);
        plan_known(CMD_CLEAR, 16'h0000, 32'h0, 32'h0, 7'd0);
        plan_item(CMD_ADD, 16'h0003);
        plan_item(CMD_ADD, 16'hFED4);
        plan_item(CMD_ADD, 16'h7FFF);
        plan_item(CMD_ADD, 16'h8000);
        plan_item(CMD_ADD, 16'h004D);
        // window shrunk below the held count, newest value only averaged
        plan_reg(REG_WINDOW_SIZE, 17'd2);
        plan_reg(REG_AVG_COUNT, 17'd1);
        plan_item(CMD_ADD, 16'h03E8);
        // average count larger than what is held
        plan_reg(REG_WINDOW_SIZE, 17'd127);
        plan_reg(REG_AVG_COUNT, 17'd5);
        plan_known(CMD_CLEAR, 16'hAAAA, 32'h0, 32'h0, 7'd0);
        plan_item(CMD_ADD, 16'h0007);
        plan_item(CMD_ADD, 16'hFFF7);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        cfg_open = 1'b0;
        foreach (plan[r])
        begin
            row = plan[r];
            if (row.is_reg)
            begin
                // registers change only with nothing in flight
                if (!cfg_open)
                begin
                    item_valid <= 1'b0;
                    wait_drained();
                    cfg_open = 1'b1;
                end
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                offer_item(row.stim, row.typed, row.want);
            end
        end
        if (cfg_open)
            cfg_valid <= 1'b0;

        // random phases, each under its own register setting
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 4)
            begin
                // long run on the full window: no idling, no clears, ring wraps,
                // and the result side holds off for a while mid-run
                program_phase(7'd127, 7'd0, 16'($urandom), 17'($urandom_range(0, 2047)));
                steady <= 1'b1;
                for (k = 0; k < LONG_RUN; k++)
                begin
                    if (k == 30)
                        squeeze_request <= 1'b1;
                    it = random_item(0);
                    offer_item(it, 1'b0, '0);
                end
                steady <= 1'b0;
            end
            else
            begin
                // mostly small windows to keep the averaging short
                case ($urandom_range(0, 9))
                    0:          ws = 7'd0;
                    1:          ws = 7'd1;
                    2:          ws = 7'd127;
                    3, 4, 5, 6: ws = 7'($urandom_range(2, 12));
                    default:    ws = 7'($urandom_range(1, 127));
                endcase
                case ($urandom_range(0, 5))
                    0, 1:    ac = 7'd0;
                    2:       ac = 7'($urandom_range(1, 3));
                    3:       ac = 7'd127;
                    default: ac = 7'($urandom_range(1, 127));
                endcase
                case ($urandom_range(0, 4))
                    0:       lb = 16'h0000;
                    1:       lb = 16'h8000;
                    2:       lb = 16'h7FFF;
                    default: lb = 16'($urandom);
                endcase
                // scale above one is taken as given
                case ($urandom_range(0, 5))
                    0:       ir = 17'd0;
                    1:       ir = INV_RANGE_RESET;
                    2:       ir = 17'h1FFFF;
                    3:       ir = 17'($urandom_range(1, 1023));
                    default: ir = 17'($urandom);
                endcase
                program_phase(ws, ac, lb, ir);
                run_len = $urandom_range(30, 70);
                repeat (run_len)
                begin
                    it = random_item(4);
                    offer_item(it, 1'b0, '0);
                end
            end
            phase++;
        end

        // stop offering, collect the rest, then watch for strays
        item_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_LEN) @(posedge clk);

        $display("covered %0d items (%0d clears), %0d register writes over %0d phases",
                 items_sent, clears_sent, reg_writes, phase);
        $display("%0d results compared, %0d faults", results_checked, fault_count);
        if (fault_count == 0 && awaited.size() == 0)
            $display("[normalized_window_average_unit] OK");
        else
            $display("[normalized_window_average_unit] ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #15000000;
        $display("watchdog expired: %0d items sent, %0d results outstanding",
                 items_sent, awaited.size());
        $display("[normalized_window_average_unit] ERROR");
        $finish;
    end

endmodule
